@@ rtl/core/bfrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrd_pkg
// Shared constants and types for the bracket frame receiver with repeat
// suppression.
// ----------------------------------------------------------------------------
package bfrd_pkg;

  localparam int FRAME_LEN = 8;
  localparam int FRAME_W   = 8 * FRAME_LEN;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] OPEN_MARK  = 8'h5B;  // '['
  localparam logic [7:0] CLOSE_MARK = 8'h5D;  // ']'
  localparam logic [7:0] DIGIT_ZERO = 8'd48;  // '0'
  localparam logic [7:0] DIGIT_BASE = 8'd10;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Outcome of checking a completed frame against the previous one
  typedef struct packed {
    logic       fresh;
    logic [7:0] number;
  } chk_t;

endpackage

@@ rtl/core/bfrd_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrd_check
// Derives the frame number from the two digit bytes and flags whether the
// frame is new or a repeat of the previous one.
// ----------------------------------------------------------------------------
module bfrd_check
  import bfrd_pkg::*;
(
  input  logic [FRAME_W-1:0] frame,
  input  logic [FRAME_W-1:0] prev_frame,
  input  logic [7:0]         prev_number,
  output chk_t               chk
);

  logic [7:0] digit_hi;
  logic [7:0] digit_lo;
  logic [7:0] number;
  logic       same;

  assign digit_hi = frame[23:16] - DIGIT_ZERO;
  assign digit_lo = frame[31:24] - DIGIT_ZERO;
  // mod 256 falls out of the 8-bit arithmetic
  assign number   = (digit_hi * DIGIT_BASE) + digit_lo;

  // bytes 2 and 3 carry the number and are left out of the compare
  assign same = (frame[15:0] == prev_frame[15:0])
             && (frame[FRAME_W-1:32] == prev_frame[FRAME_W-1:32]);

  assign chk.fresh  = !((number > prev_number) && same);
  assign chk.number = number;

endmodule

@@ rtl/core/bracket_frame_receiver_dedup_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_frame_receiver_dedup_unit
// Assembles '['...']' framed 8-byte messages from a byte stream and passes on
// only frames that are not repeats of the previous one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_rx_byte) takes one received byte
//   per transfer. Result channel (out_valid / out_ready / out_frame_data /
//   out_frame_number) carries one completed, non-repeated frame per transfer,
//   byte 0 in bits 7..0.
//   A byte is taken every cycle while in_ready is high. The closing ']'
//   transfer that completes a frame produces its result on out_* in the next
//   cycle; bytes that complete no frame, and repeated frames, produce nothing.
//   All per-byte work is one pass of compare and constant-multiply logic
//   between the state registers and the single output register, so the rate
//   is one byte per cycle while no result waits on a low out_ready.
//   Reset (rst_n low, synchronous) clears the position counter, the output
//   valid, the previous frame number and sets the previous frame to spaces.
//   When the receiver stalls with a result pending, in_ready drops until that
//   result is taken; in_ready stays high in the cycle the result is taken.
// ----------------------------------------------------------------------------
module bracket_frame_receiver_dedup_unit
  import bfrd_pkg::*;
#(
  parameter int BUF_LIMIT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAME_W-1:0] out_frame_data,
  output logic [7:0]         out_frame_number
);

  localparam int CNT_W = $clog2(BUF_LIMIT + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt, pos;
  logic [7:0]         store_r [FRAME_LEN-1];
  logic [FRAME_W-1:0] prev_frame_r;
  logic [7:0]         prev_number_r;
  logic               out_valid_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [7:0]         out_number_r;

  logic               accept;
  logic               store_en;
  logic [IDX_W-1:0]   store_idx;
  logic               complete;
  logic               emit;
  logic [FRAME_W-1:0] frame;
  chk_t               chk;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // position after this byte
  always_comb begin
    if (in_rx_byte == OPEN_MARK) begin
      pos = CNT_W'(1);
    end else if (cnt_r < CNT_W'(BUF_LIMIT)) begin
      pos = cnt_r + CNT_W'(1);
    end else begin
      pos = cnt_r;
    end
  end

  assign store_en  = (pos >= CNT_W'(1)) && (pos <= CNT_W'(FRAME_LEN));
  assign store_idx = IDX_W'(pos - CNT_W'(1));
  assign complete  = (in_rx_byte == CLOSE_MARK) && (pos == CNT_W'(FRAME_LEN));
  assign cnt_nxt   = complete ? '0 : pos;

  // on completion the current byte is the last frame byte
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      frame[8*i +: 8] = store_r[i];
    end
    frame[FRAME_W-1 -: 8] = in_rx_byte;
  end

  bfrd_check u_check (
    .frame       (frame),
    .prev_frame  (prev_frame_r),
    .prev_number (prev_number_r),
    .chk         (chk)
  );

  assign emit = complete && chk.fresh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      prev_number_r <= '0;
      prev_frame_r  <= {FRAME_LEN{SPACE_CHAR}};
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= emit;
        if (complete) begin
          prev_number_r <= chk.number;
          prev_frame_r  <= frame;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // frame bytes and result payload carry no reset
  always_ff @(posedge clk) begin
    if (accept && store_en && (store_idx != IDX_W'(FRAME_LEN - 1))) begin
      store_r[store_idx] <= in_rx_byte;
    end
    if (accept && emit) begin
      out_frame_r  <= frame;
      out_number_r <= chk.number;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_data   = out_frame_r;
  assign out_frame_number = out_number_r;

`ifndef SYNTH
  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BUF_LIMIT))
    else $error("position counter beyond buffer limit");

  a_close_clears : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_rx_byte == CLOSE_MARK) && (cnt_r == CNT_W'(FRAME_LEN - 1))
    |=> cnt_r == '0)
    else $error("completed frame did not clear position counter");

  a_open_restarts : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_rx_byte == OPEN_MARK) |=> cnt_r == CNT_W'(1))
    else $error("open mark did not restart position counter");

  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && (in_rx_byte == CLOSE_MARK)))
    else $error("result raised without a closing byte transfer");
`endif

endmodule

@@ tb/bracket_frame_receiver_dedup_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_frame_receiver_dedup_unit_test
// Drives bracketed byte frames, broken frames and noise into the receiver,
// predicts which frames survive repeat suppression and checks every result
// transfer field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bracket_frame_receiver_dedup_unit_test;
  import bfrd_pkg::*;

  localparam int BUF_LIMIT    = 64;
  localparam int RANDOM_BYTES = 1550;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 20000;

  typedef struct packed {
    logic [FRAME_W-1:0] data;
    logic [7:0]         num;
  } frame_t;

  // How the closing byte of a directed row is checked
  typedef enum logic [1:0] {ROW_PREDICT, ROW_FRAME, ROW_NONE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [3:0]         len;
    logic [95:0]        seq;       // first byte in the most significant used slot
    logic [FRAME_W-1:0] exp_data;  // byte 0 in the low bits, so the text reads reversed
    logic [7:0]         exp_num;
  } dir_row_t;

  localparam int DIR_ROWS = 9;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{ROW_FRAME,   4'd8, "[A12BCD]",  "]DCB21A[", 8'd12},  // first frame after reset
    '{ROW_NONE,    4'd8, "[A13BCD]",  64'd0,      8'd0},   // higher number, same body
    '{ROW_FRAME,   4'd8, "[A13BCD]",  "]DCB31A[", 8'd13},  // equal number is not a repeat
    '{ROW_PREDICT, 4'd8, "[Z]1BCD]",  64'd0,      8'd0},   // close mark inside, non-digit
    '{ROW_PREDICT, 4'd8, 96'h5B00FF00FF00FF5D, 64'd0, 8'd0},
    '{ROW_NONE,    4'd9, "[A12BCDE]", 64'd0,      8'd0},   // overlong, no completion
    '{ROW_PREDICT, 4'd8, "[A12BCD]",  64'd0,      8'd0},
    '{ROW_FRAME,   4'd8, "xA55BCD]",  "]DCB55Ax", 8'd55},  // no open mark, counter at zero
    '{ROW_NONE,    4'd8, "xA56BCD]",  64'd0,      8'd0}
  };

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'd0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [FRAME_W-1:0] out_frame_data;
  logic [7:0]         out_frame_number;

  // predictor state
  logic [6:0] rx_pos = 7'd0;
  logic [7:0] rx_store   [FRAME_LEN];
  logic [7:0] last_frame [FRAME_LEN];
  logic [7:0] last_num = 8'd0;

  frame_t pending_frames [$];
  int     errors         = 0;
  int     bytes_sent     = 0;
  int     frames_done    = 0;
  int     repeats        = 0;
  int     frames_checked = 0;
  int     hold_reqs      = 0;
  bit     calm_mode      = 1'b0;

  always #2 clk = ~clk;

  bracket_frame_receiver_dedup_unit #(
    .BUF_LIMIT(BUF_LIMIT)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_data  (out_frame_data),
    .out_frame_number(out_frame_number)
  );

  // Mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Advance the receiver by one byte; emit is set when a fresh frame completes
  function automatic void assemble_byte(input logic [7:0] c, output logic emit,
                                        output frame_t fr);
    logic [7:0] d2, d3, num;
    logic       same;
    int         i;
    emit = 1'b0;
    fr   = '0;
    if (c == OPEN_MARK) rx_pos = 7'd1;
    else if (rx_pos < BUF_LIMIT) rx_pos = rx_pos + 7'd1;
    if (rx_pos >= 1 && rx_pos <= FRAME_LEN) rx_store[rx_pos - 1] = c;
    if (c == CLOSE_MARK && rx_pos == FRAME_LEN) begin
      rx_pos = 7'd0;
      frames_done++;
      d2   = rx_store[2] - DIGIT_ZERO;
      d3   = rx_store[3] - DIGIT_ZERO;
      num  = d2 * DIGIT_BASE + d3;
      same = rx_store[0] == last_frame[0] && rx_store[1] == last_frame[1] &&
             rx_store[4] == last_frame[4] && rx_store[5] == last_frame[5] &&
             rx_store[6] == last_frame[6] && rx_store[7] == last_frame[7];
      emit = !((num > last_num) && same);
      if (!emit) repeats++;
      last_num   = num;
      last_frame = rx_store;
      for (i = 0; i < FRAME_LEN; i++) fr.data[8*i +: 8] = rx_store[i];
      fr.num = num;
    end
  endfunction

  // One byte transfer; typed rows replace the predicted outcome of their last byte
  task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_has,
                           input frame_t typed_fr);
    int     gap;
    logic   emit;
    frame_t fr;
    gap = calm_mode ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    assemble_byte(b, emit, fr);
    if (typed) begin
      if (typed_has) pending_frames.push_back(typed_fr);
    end else if (emit) begin
      pending_frames.push_back(fr);
    end
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [FRAME_W-1:0] exp_v,
                               input logic [FRAME_W-1:0] act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // Result monitor
  always @(posedge clk) begin
    frame_t exp_fr;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        note_mismatch("unexpected frame", '0, out_frame_data);
      end else begin
        exp_fr = pending_frames.pop_front();
        frames_checked++;
        if (out_frame_data !== exp_fr.data)
          note_mismatch("frame_data", exp_fr.data, out_frame_data);
        if (out_frame_number !== exp_fr.num)
          note_mismatch("frame_number", exp_fr.num, out_frame_number);
      end
    end
  end

  // Result side: random stalls plus the requested long hold-off
  initial begin
    int   stall;
    int   seen;
    logic r;
    stall = 0;
    seen  = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != seen) begin
        seen  = hold_reqs;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        r = 1'b0;
      end else if (calm_mode) begin
        r = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = idle_cycles();
        r     = (stall == 0);
        if (stall > 0) stall--;
      end else begin
        r = 1'b1;
      end
      out_ready <= r;
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] tmpl [FRAME_LEN];
    logic [7:0] fb   [FRAME_LEN];
    frame_t     typed_fr;
    dir_row_t   row;
    int         r, k, sel, n, m, tmpl_val, target, wait_cnt;
    bit         held, paused;

    foreach (last_frame[i]) last_frame[i] = SPACE_CHAR;
    foreach (rx_store[i]) rx_store[i] = 8'd0;
    foreach (tmpl[i]) tmpl[i] = "A";
    tmpl_val = 0;
    held     = 1'b0;
    paused   = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      row           = DIR_TBL[r];
      typed_fr.data = row.exp_data;
      typed_fr.num  = row.exp_num;
      for (k = 0; k < row.len; k++)
        send_byte(row.seq[8*(row.len - 1 - k) +: 8],
                  (k == row.len - 1) && (row.kind != ROW_PREDICT),
                  row.kind == ROW_FRAME, typed_fr);
    end

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      calm_mode = ((bytes_sent / 200) % 4) == 1;
      if (!held && bytes_sent > 500) begin
        held = 1'b1;
        hold_reqs++;
      end
      if (!paused && bytes_sent > 1000) begin
        // let everything drain before going on
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_frames.size() != 0) @(negedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        // noise, sometimes long enough to saturate the position counter
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
          m = $urandom_range(0, 9);
          send_byte(m == 0 ? OPEN_MARK : m == 1 ? CLOSE_MARK : 8'($urandom_range(0, 255)),
                    1'b0, 1'b0, '0);
        end
      end else begin
        m = $urandom_range(0, 99);
        if (m < 55) begin
          tmpl_val = $urandom_range(0, 1) ? (tmpl_val + 1) % 100 : $urandom_range(0, 99);
        end else if (m < 85) begin
          tmpl[1] = 8'("A" + $urandom_range(0, 3));
          for (k = 4; k < 7; k++) tmpl[k] = 8'("A" + $urandom_range(0, 3));
          tmpl_val = $urandom_range(0, 99);
        end
        for (k = 0; k < FRAME_LEN; k++) fb[k] = tmpl[k];
        fb[2] = DIGIT_ZERO + 8'(tmpl_val / 10);
        fb[3] = DIGIT_ZERO + 8'(tmpl_val % 10);
        if (m >= 85)
          for (k = 1; k < 7; k++) fb[k] = 8'($urandom_range(0, 255));
        fb[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : OPEN_MARK;
        fb[7] = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : CLOSE_MARK;
        for (k = 0; k < FRAME_LEN; k++) send_byte(fb[k], 1'b0, 1'b0, '0);
      end
    end
    in_valid  <= 1'b0;
    calm_mode = 1'b0;

    wait_cnt = 0;
    while (pending_frames.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    if (pending_frames.size() != 0) begin
      errors += pending_frames.size();
      $display("%0d expected frames never arrived", pending_frames.size());
    end

    $display("sent %0d bytes: %0d frames completed, %0d dropped as repeats",
             bytes_sent, frames_done, repeats);
    $display("checked %0d frame transfers, %0d errors", frames_checked, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
